[src/power_spectrum_descriptor_atoms_assert.svh]
// Assertion macros for the descriptor block.
`ifndef POWER_SPECTRUM_DESCRIPTOR_ATOMS_ASSERT_SVH
`define POWER_SPECTRUM_DESCRIPTOR_ATOMS_ASSERT_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("psd assertion failed");
`define PSD_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("psd assertion failed");
`else
`define PSD_ASSERT_IMP(label, clk, rst_n, pre, post)
`define PSD_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

[src/psd_pkg.sv]
`timescale 1ns / 1ps
package psd_pkg;

	localparam int DEF_MAX_RADIAL    = 8;
	localparam int DEF_MAX_DEGREE    = 3;
	localparam int DEF_MAX_NEIGHBORS = 32;
	localparam int NUM_COMPONENTS    = 3;

	localparam logic [1:0] REG_RADIAL_COUNT = 2'd0;
	localparam logic [1:0] REG_MAX_DEGREE   = 2'd1;

	localparam logic signed [63:0] INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [2:0] {
		CMD_LOAD_COEF  = 3'd0,
		CMD_LOAD_DERIV = 3'd1,
		CMD_COMPUTE    = 3'd2,
		CMD_READ_DESC  = 3'd3,
		CMD_READ_DERIV = 3'd4,
		CMD_READ_NORM  = 3'd5,
		CMD_READ_DOT   = 3'd6
	} cmd_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] value;
	} q24_t;

	typedef struct packed {
		logic busy;
		logic desc_we;
		logic dd_we;
		logic dot_we;
	} eng_ctl_t;

	function automatic int idx_w(input int depth);
		idx_w = (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat_add = s[64] ? INT64_MIN : INT64_MAX;
		end else begin
			sat_add = s[63:0];
		end
	endfunction

	// Q16.48 to Q8.24, round half up, clip to int32
	function automatic q24_t to_q24(input logic [63:0] x);
		logic [40:0] q;
		q24_t r;
		q = {x[63], x[63:24]} + {40'd0, x[23]};
		if (q[40:31] == {10{q[31]}}) begin
			r.sat = 1'b0;
			r.value = q[31:0];
		end else begin
			r.sat = 1'b1;
			r.value = q[40] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		to_q24 = r;
	endfunction

endpackage

[src/psd_ram.sv]
`timescale 1ns / 1ps
module psd_ram import psd_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [idx_w(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]        wdata,
	input  logic [idx_w(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/psd_isqrt.sv]
`timescale 1ns / 1ps
module psd_isqrt import psd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] x_q, res_q, bit_q, sum;
	logic        busy_q, done_q;

	assign sum = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per step, 32 steps
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (x_q >= sum) begin
				x_q   <= x_q - sum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

[src/psd_engine.sv]
`timescale 1ns / 1ps
module psd_engine import psd_pkg::*; #(
	parameter int MAX_RADIAL    = DEF_MAX_RADIAL,
	parameter int MAX_DEGREE    = DEF_MAX_DEGREE,
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
	localparam int HARM       = (MAX_DEGREE + 1) * (MAX_DEGREE + 1),
	localparam int COEF_DEPTH = MAX_RADIAL * HARM,
	localparam int ROW_DEPTH  = NUM_COMPONENTS * MAX_NEIGHBORS,
	localparam int DESC_DEPTH = (MAX_RADIAL * (MAX_RADIAL + 1) / 2) * (MAX_DEGREE + 1),
	localparam int C_AW  = idx_w(COEF_DEPTH),
	localparam int DC_AW = idx_w(ROW_DEPTH * COEF_DEPTH),
	localparam int DS_AW = idx_w(DESC_DEPTH),
	localparam int DD_AW = idx_w(ROW_DEPTH * DESC_DEPTH),
	localparam int R_AW  = idx_w(ROW_DEPTH),
	localparam int K_W   = $clog2(DESC_DEPTH + 1),
	localparam int P_W   = $clog2(ROW_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [3:0]       radial_count,
	input  logic [1:0]       max_degree,
	input  logic [5:0]       neighbor_total,
	input  logic [31:0]      coef_rdata,
	input  logic [31:0]      dcoef_rdata,
	input  logic [63:0]      desc_rdata,
	input  logic [63:0]      dd_rdata,
	output eng_ctl_t         ctl,
	output logic [C_AW-1:0]  coef_raddr,
	output logic [DC_AW-1:0] dcoef_raddr,
	output logic [DS_AW-1:0] desc_raddr,
	output logic [DS_AW-1:0] desc_waddr,
	output logic [DD_AW-1:0] dd_raddr,
	output logic [DD_AW-1:0] dd_waddr,
	output logic [R_AW-1:0]  dot_waddr,
	output logic [63:0]      wdata,
	output logic [K_W-1:0]   k_count,
	output logic [P_W-1:0]   row_count,
	output logic [31:0]      norm
);

	localparam int RN_W = $clog2(MAX_RADIAL + 1);
	localparam int LD_W = idx_w(MAX_DEGREE + 1);
	localparam int M_W  = idx_w(2 * MAX_DEGREE + 1);

	typedef enum logic [16:0] {
		E_IDLE = 17'h00001,
		E_RD1  = 17'h00002,
		E_RD2  = 17'h00004,
		E_MUL  = 17'h00008,
		E_ADD1 = 17'h00010,
		E_ADD2 = 17'h00020,
		E_WR   = 17'h00040,
		E_NRD  = 17'h00080,
		E_NRND = 17'h00100,
		E_NMUL = 17'h00200,
		E_NADD = 17'h00400,
		E_SQRT = 17'h00800,
		E_DRD  = 17'h01000,
		E_DRND = 17'h02000,
		E_DMUL = 17'h04000,
		E_DADD = 17'h08000,
		E_DWR  = 17'h10000
	} estate_t;

	estate_t            state_q;
	logic [RN_W-1:0]    r_q, n1_q, n2_q;
	logic [LD_W-1:0]    deg_q, l_q;
	logic [M_W-1:0]     m_q;
	logic [P_W-1:0]     rows_q, pass_q;
	logic [K_W-1:0]     k_q, j_q;
	logic signed [31:0] c1_q, c2_q, d1_q, d2_q, va_q, vb_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod_q, acc_q, prod_w;
	logic [63:0]        sumsq_q;
	logic [64:0]        sumsq_w;
	logic [31:0]        norm_q, root;
	logic               sqrt_start, sqrt_done;
	logic [31:0]        h_w, lsq_w, i1_w, i2_w, row_w, r_w, nt_w, deg_w;
	logic               last_m, last_pass, last_elem;
	q24_t               qa, qb;

	always_comb begin
		h_w   = (32'(deg_q) + 32'd1) * (32'(deg_q) + 32'd1);
		lsq_w = 32'(l_q) * 32'(l_q);
		i1_w  = 32'(n1_q) * h_w + lsq_w + 32'(m_q);
		i2_w  = 32'(n2_q) * h_w + lsq_w + 32'(m_q);
		row_w = (pass_q == '0) ? 32'd0 : 32'(pass_q) - 32'd1;
		r_w   = (32'(radial_count) > MAX_RADIAL) ? MAX_RADIAL : 32'(radial_count);
		deg_w = (32'(max_degree) > MAX_DEGREE) ? MAX_DEGREE : 32'(max_degree);
		nt_w  = (32'(neighbor_total) > MAX_NEIGHBORS) ? MAX_NEIGHBORS
			: 32'(neighbor_total);
	end

	assign last_m    = 32'(m_q) == 32'(l_q) * 32'd2;
	assign last_pass = pass_q == rows_q;
	assign last_elem = (l_q == deg_q) && (32'(n1_q) + 32'd1 == 32'(r_q))
		&& (32'(n2_q) + 32'd1 == 32'(r_q));

	assign coef_raddr  = (state_q == E_RD2) ? C_AW'(i2_w) : C_AW'(i1_w);
	assign dcoef_raddr = (state_q == E_RD2) ? DC_AW'(row_w * COEF_DEPTH + i1_w)
		: DC_AW'(row_w * COEF_DEPTH + i2_w);
	assign desc_raddr  = DS_AW'(j_q);
	assign dd_raddr    = DD_AW'(32'(pass_q) * DESC_DEPTH + 32'(j_q));
	assign desc_waddr  = DS_AW'(k_q);
	assign dd_waddr    = DD_AW'(row_w * DESC_DEPTH + 32'(k_q));
	assign dot_waddr   = R_AW'(pass_q);
	assign wdata       = acc_q;

	assign ctl.busy    = state_q != E_IDLE;
	assign ctl.desc_we = (state_q == E_WR) && (pass_q == '0);
	assign ctl.dd_we   = (state_q == E_WR) && (pass_q != '0);
	assign ctl.dot_we  = state_q == E_DWR;

	assign k_count   = k_q;
	assign row_count = rows_q;
	assign norm      = norm_q;

	// single shared multiplier
	always_comb begin
		ma = c1_q;
		mb = d2_q;
		unique case (state_q)
			E_MUL: begin
				ma = c1_q;
				mb = (pass_q == '0) ? coef_rdata : d2_q;
			end
			E_ADD1: begin
				ma = d1_q;
				mb = c2_q;
			end
			E_NMUL: begin
				ma = va_q;
				mb = va_q;
			end
			E_DMUL: begin
				ma = va_q;
				mb = vb_q;
			end
			default: begin
				ma = c1_q;
				mb = d2_q;
			end
		endcase
	end

	assign prod_w  = ma * mb;
	assign sumsq_w = {1'b0, sumsq_q} + {1'b0, prod_q};
	assign qa      = to_q24(dd_rdata);
	assign qb      = to_q24(desc_rdata);
	assign sqrt_start = (state_q == E_NRD) && (j_q == k_q);

	psd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sumsq_q),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			k_q     <= '0;
			rows_q  <= '0;
			norm_q  <= '0;
			r_q     <= '0;
			deg_q   <= '0;
			n1_q    <= '0;
			n2_q    <= '0;
			l_q     <= '0;
			m_q     <= '0;
			pass_q  <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						r_q    <= RN_W'(r_w);
						deg_q  <= LD_W'(deg_w);
						rows_q <= P_W'(nt_w * NUM_COMPONENTS);
						n1_q   <= '0;
						n2_q   <= '0;
						l_q    <= '0;
						m_q    <= '0;
						pass_q <= '0;
						k_q    <= '0;
						j_q    <= '0;
						state_q <= (r_w == 32'd0) ? E_NRD : E_RD1;
					end
				end
				E_RD1: state_q <= E_RD2;
				E_RD2: state_q <= E_MUL;
				E_MUL: state_q <= E_ADD1;
				E_ADD1, E_ADD2: begin
					if (state_q == E_ADD1 && pass_q != '0) begin
						state_q <= E_ADD2;
					end else if (last_m) begin
						state_q <= E_WR;
					end else begin
						m_q <= m_q + 1'b1;
						state_q <= E_RD1;
					end
				end
				E_WR: begin
					m_q <= '0;
					if (last_pass) begin
						pass_q <= '0;
						k_q <= k_q + 1'b1;
						if (last_elem) begin
							j_q <= '0;
							state_q <= E_NRD;
						end else begin
							state_q <= E_RD1;
							if (l_q != deg_q) begin
								l_q <= l_q + 1'b1;
							end else begin
								l_q <= '0;
								if (32'(n2_q) + 32'd1 < 32'(r_q)) begin
									n2_q <= n2_q + 1'b1;
								end else begin
									n1_q <= n1_q + 1'b1;
									n2_q <= n1_q + 1'b1;
								end
							end
						end
					end else begin
						pass_q <= pass_q + 1'b1;
						state_q <= E_RD1;
					end
				end
				E_NRD:  state_q <= (j_q == k_q) ? E_SQRT : E_NRND;
				E_NRND: state_q <= E_NMUL;
				E_NMUL: state_q <= E_NADD;
				E_NADD: begin
					j_q <= j_q + 1'b1;
					state_q <= E_NRD;
				end
				E_SQRT: begin
					if (sqrt_done) begin
						norm_q <= root;
						pass_q <= '0;
						j_q <= '0;
						state_q <= E_DRD;
					end
				end
				E_DRD: begin
					if (last_pass) begin
						state_q <= E_IDLE;
					end else begin
						state_q <= (j_q == k_q) ? E_DWR : E_DRND;
					end
				end
				E_DRND: state_q <= E_DMUL;
				E_DMUL: state_q <= E_DADD;
				E_DADD: begin
					j_q <= j_q + 1'b1;
					state_q <= E_DRD;
				end
				E_DWR: begin
					j_q <= '0;
					pass_q <= pass_q + 1'b1;
					state_q <= E_DRD;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				acc_q   <= '0;
				sumsq_q <= '0;
			end
			E_RD2: begin
				c1_q <= coef_rdata;
				d2_q <= dcoef_rdata;
			end
			E_MUL: begin
				c2_q   <= coef_rdata;
				d1_q   <= dcoef_rdata;
				prod_q <= prod_w;
			end
			E_ADD1: begin
				acc_q  <= sat_add(acc_q, prod_q);
				prod_q <= prod_w;
			end
			E_ADD2: acc_q <= sat_add(acc_q, prod_q);
			E_WR:   acc_q <= '0;
			E_NRND: va_q <= qb.value;
			E_NMUL: prod_q <= prod_w;
			E_NADD: sumsq_q <= sumsq_w[64] ? '1 : sumsq_w[63:0];
			E_SQRT: acc_q <= '0;
			E_DRND: begin
				va_q <= qa.value;
				vb_q <= qb.value;
			end
			E_DMUL: prod_q <= prod_w;
			E_DADD: acc_q <= sat_add(acc_q, prod_q);
			E_DWR:  acc_q <= '0;
			default: begin
			end
		endcase
	end

endmodule

[src/power_spectrum_descriptor_atoms.sv]
`timescale 1ns / 1ps
// Channel | Direction | Signals                          | Transaction
// s_      | in        | s_tvalid s_tready s_tdata[63:0]  | one command
// m_      | out       | m_tvalid m_tready m_tdata m_tuser| one read result
// cfg_    | in        | cfg_valid cfg_ready cfg_index/data| one register write
// Loads are written when accepted; reads go through the registered memory port.
// Compute runs in a read-modify-write sequencer: each descriptor k is accumulated
// with its derivative rows, then the norm is formed (32-step root), and then the
// dot products, one per derivative row.
// Reset clears counts, so all reads return zero until a compute; no clearing pass.
// A read result waits in the output register; commands stall while it is held.
`include "power_spectrum_descriptor_atoms_assert.svh"
module power_spectrum_descriptor_atoms import psd_pkg::*; #(
	parameter int MAX_RADIAL    = DEF_MAX_RADIAL,
	parameter int MAX_DEGREE    = DEF_MAX_DEGREE,
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[2:0] coef_index[9:3] desc_index[17:10] deriv_row[24:18]
	// load_value[56:25] neighbor_total[62:57] zero[63]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[31:0]
	output logic [31:0] m_tdata,
	// saturated[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int HARM       = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
	localparam int COEF_DEPTH = MAX_RADIAL * HARM;
	localparam int ROW_DEPTH  = NUM_COMPONENTS * MAX_NEIGHBORS;
	localparam int DESC_DEPTH = (MAX_RADIAL * (MAX_RADIAL + 1) / 2) * (MAX_DEGREE + 1);
	localparam int C_AW  = idx_w(COEF_DEPTH);
	localparam int DC_AW = idx_w(ROW_DEPTH * COEF_DEPTH);
	localparam int DS_AW = idx_w(DESC_DEPTH);
	localparam int DD_AW = idx_w(ROW_DEPTH * DESC_DEPTH);
	localparam int R_AW  = idx_w(ROW_DEPTH);
	localparam int K_W   = $clog2(DESC_DEPTH + 1);
	localparam int P_W   = $clog2(ROW_DEPTH + 1);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_READ = 3'b010,
		T_COMP = 3'b100
	} tstate_t;

	tstate_t          state_q;
	logic [3:0]       radial_count_q;
	logic [1:0]       max_degree_q;
	logic             out_valid_q, out_sat_q;
	logic [31:0]      out_data_q;
	cmd_t             rd_cmd_s1;
	logic             rd_ok_s1;

	cmd_t             cmd;
	logic [6:0]       coef_index, deriv_row;
	logic [7:0]       desc_index;
	logic [31:0]      load_value;
	logic [5:0]       neighbor_total;
	logic             accept, is_read, rd_ok, start;
	logic             coef_ok, row_ok, coef_we, dcoef_we;

	eng_ctl_t         ctl;
	logic [C_AW-1:0]  coef_raddr;
	logic [DC_AW-1:0] dcoef_raddr;
	logic [DS_AW-1:0] eng_desc_raddr, desc_waddr, desc_raddr;
	logic [DD_AW-1:0] eng_dd_raddr, dd_waddr, dd_raddr;
	logic [R_AW-1:0]  dot_waddr;
	logic [63:0]      wdata, desc_rdata, dd_rdata, dot_rdata;
	logic [31:0]      coef_rdata, dcoef_rdata, norm;
	logic [K_W-1:0]   k_count;
	logic [P_W-1:0]   row_count;
	q24_t             rd_q;

	assign cmd            = cmd_t'(s_tdata[2:0]);
	assign coef_index     = s_tdata[9:3];
	assign desc_index     = s_tdata[17:10];
	assign deriv_row      = s_tdata[24:18];
	assign load_value     = s_tdata[56:25];
	assign neighbor_total = s_tdata[62:57];

	assign s_tready  = (state_q == T_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign coef_ok  = 32'(coef_index) < COEF_DEPTH;
	assign row_ok   = 32'(deriv_row) < 32'(row_count);
	assign coef_we  = accept && (cmd == CMD_LOAD_COEF) && coef_ok;
	assign dcoef_we = accept && (cmd == CMD_LOAD_DERIV) && coef_ok
		&& (32'(deriv_row) < ROW_DEPTH);
	assign start    = accept && (cmd == CMD_COMPUTE);

	always_comb begin
		is_read = 1'b0;
		rd_ok   = 1'b0;
		unique case (cmd)
			CMD_READ_DESC: begin
				is_read = 1'b1;
				rd_ok = 32'(desc_index) < 32'(k_count);
			end
			CMD_READ_DERIV: begin
				is_read = 1'b1;
				rd_ok = (32'(desc_index) < 32'(k_count)) && row_ok;
			end
			CMD_READ_NORM: begin
				is_read = 1'b1;
				rd_ok = 1'b1;
			end
			CMD_READ_DOT: begin
				is_read = 1'b1;
				rd_ok = row_ok;
			end
			default: begin
				is_read = 1'b0;
				rd_ok = 1'b0;
			end
		endcase
	end

	assign desc_raddr = ctl.busy ? eng_desc_raddr : DS_AW'(desc_index);
	assign dd_raddr   = ctl.busy ? eng_dd_raddr
		: DD_AW'(32'(deriv_row) * DESC_DEPTH + 32'(desc_index));

	psd_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
		.clk (clk), .we (coef_we), .waddr (C_AW'(coef_index)), .wdata (load_value),
		.raddr (coef_raddr), .rdata (coef_rdata)
	);

	psd_ram #(.WIDTH(32), .DEPTH(ROW_DEPTH * COEF_DEPTH)) u_dcoef_ram (
		.clk (clk), .we (dcoef_we),
		.waddr (DC_AW'(32'(deriv_row) * COEF_DEPTH + 32'(coef_index))),
		.wdata (load_value), .raddr (dcoef_raddr), .rdata (dcoef_rdata)
	);

	psd_ram #(.WIDTH(64), .DEPTH(DESC_DEPTH)) u_desc_ram (
		.clk (clk), .we (ctl.desc_we), .waddr (desc_waddr), .wdata (wdata),
		.raddr (desc_raddr), .rdata (desc_rdata)
	);

	psd_ram #(.WIDTH(64), .DEPTH(ROW_DEPTH * DESC_DEPTH)) u_dd_ram (
		.clk (clk), .we (ctl.dd_we), .waddr (dd_waddr), .wdata (wdata),
		.raddr (dd_raddr), .rdata (dd_rdata)
	);

	psd_ram #(.WIDTH(64), .DEPTH(ROW_DEPTH)) u_dot_ram (
		.clk (clk), .we (ctl.dot_we), .waddr (dot_waddr), .wdata (wdata),
		.raddr (R_AW'(deriv_row)), .rdata (dot_rdata)
	);

	psd_engine #(
		.MAX_RADIAL    (MAX_RADIAL),
		.MAX_DEGREE    (MAX_DEGREE),
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.radial_count   (radial_count_q),
		.max_degree     (max_degree_q),
		.neighbor_total (neighbor_total),
		.coef_rdata     (coef_rdata),
		.dcoef_rdata    (dcoef_rdata),
		.desc_rdata     (desc_rdata),
		.dd_rdata       (dd_rdata),
		.ctl            (ctl),
		.coef_raddr     (coef_raddr),
		.dcoef_raddr    (dcoef_raddr),
		.desc_raddr     (eng_desc_raddr),
		.desc_waddr     (desc_waddr),
		.dd_raddr       (eng_dd_raddr),
		.dd_waddr       (dd_waddr),
		.dot_waddr      (dot_waddr),
		.wdata          (wdata),
		.k_count        (k_count),
		.row_count      (row_count),
		.norm           (norm)
	);

	always_comb begin
		unique case (rd_cmd_s1)
			CMD_READ_DESC:  rd_q = to_q24(desc_rdata);
			CMD_READ_DERIV: rd_q = to_q24(dd_rdata);
			CMD_READ_DOT:   rd_q = to_q24(dot_rdata);
			CMD_READ_NORM: begin
				rd_q.sat = norm[31];
				rd_q.value = norm[31] ? 32'h7fff_ffff : norm;
			end
			default: rd_q = '0;
		endcase
		if (!rd_ok_s1) begin
			rd_q = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_IDLE;
			radial_count_q <= 4'd8;
			max_degree_q   <= 2'd3;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_RADIAL_COUNT) begin
					radial_count_q <= cfg_data;
				end else if (cfg_index == REG_MAX_DEGREE) begin
					max_degree_q <= cfg_data[1:0];
				end
			end
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept && is_read) begin
						state_q <= T_READ;
					end else if (start) begin
						state_q <= T_COMP;
					end
				end
				T_READ: begin
					out_valid_q <= 1'b1;
					state_q <= T_IDLE;
				end
				T_COMP: begin
					if (!ctl.busy) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_cmd_s1 <= cmd;
			rd_ok_s1  <= rd_ok;
		end
		if (state_q == T_READ) begin
			out_data_q <= rd_q.value;
			out_sat_q  <= rd_q.sat;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_sat_q;

	`PSD_ASSERT_IMP(a_no_accept_busy, clk, arst_n, accept, !ctl.busy)
	`PSD_ASSERT_IMP(a_we_only_busy, clk, arst_n, ctl.desc_we || ctl.dd_we || ctl.dot_we, ctl.busy)
	`PSD_ASSERT_NXT(a_read_follows, clk, arst_n, accept && is_read, state_q == T_READ)
	`PSD_ASSERT_IMP(a_out_free, clk, arst_n, state_q == T_READ, !out_valid_q)

endmodule

[tb/sv/tb_power_spectrum_descriptor_atoms.sv]
`timescale 1ns / 1ps
module tb_power_spectrum_descriptor_atoms;
	import psd_pkg::*;

	localparam int NCOEF = 128;
	localparam int NROW  = 96;
	localparam int NDESC = 144;

	typedef struct {
		logic [31:0] data;
		logic        sat;
	} read_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [3:0]  cfg_data = '0;

	power_spectrum_descriptor_atoms i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [63:0]  cmd_q[$];
	read_result_t read_results_q[$];
	int           errors = 0;
	int           n_results = 0;
	int           n_computes = 0;
	bit           quiet = 1'b0;

	// predictor state
	int unsigned  pr_radial = 8;
	int unsigned  pr_degree = 3;
	int           coef_mem[NCOEF];
	int           dcoef_mem[NROW][NCOEF];
	longint       desc_acc[NDESC];
	longint       dd_acc[NROW][NDESC];
	longint       dot_acc[NROW];
	int unsigned  norm_val = 0;

	// generator bookkeeping for written entries
	int unsigned  gen_radial = 8;
	int unsigned  gen_degree = 3;
	bit           coef_w[NCOEF];
	bit           dcoef_w[NROW][NCOEF];

	function automatic longint add_sat64(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(signed'(a)) + 65'(signed'(b));
		if (s > 65'sh0_7fff_ffff_ffff_ffff) return INT64_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return INT64_MIN;
		return longint'(s[63:0]);
	endfunction

	function automatic read_result_t round_q24(longint x);
		read_result_t r;
		longint q;
		q = (x >>> 24) + longint'(x[23]);
		r.sat = 1'b0;
		if (q > 64'sh7fff_ffff) begin
			r.sat = 1'b1;
			r.data = 32'h7fff_ffff;
		end else if (q < -64'sh8000_0000) begin
			r.sat = 1'b1;
			r.data = 32'h8000_0000;
		end else begin
			r.data = q[31:0];
		end
		return r;
	endfunction

	function automatic int unsigned root64(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res[31:0];
	endfunction

	function automatic void run_spectrum(int unsigned ntot);
		int unsigned r, deg, h, nt, rows, k, i1, i2;
		longint unsigned sumsq, sq;
		longint c1, c2, a, v, s;
		int rounded[NDESC];
		r = (pr_radial > 8) ? 8 : pr_radial;
		deg = pr_degree;
		h = (deg + 1) * (deg + 1);
		nt = (ntot > 32) ? 32 : ntot;
		rows = 3 * nt;
		k = 0;
		sumsq = 0;
		foreach (desc_acc[j]) desc_acc[j] = 0;
		foreach (dot_acc[j]) dot_acc[j] = 0;
		foreach (dd_acc[a1, b1]) dd_acc[a1][b1] = 0;
		for (int n1 = 0; n1 < r; n1++)
			for (int n2 = n1; n2 < r; n2++)
				for (int l = 0; l <= deg; l++) begin
					for (int m = 0; m < 2 * l + 1; m++) begin
						i1 = n1 * h + l * l + m;
						i2 = n2 * h + l * l + m;
						c1 = coef_mem[i1];
						c2 = coef_mem[i2];
						desc_acc[k] = add_sat64(desc_acc[k], c1 * c2);
						for (int row = 0; row < rows; row++) begin
							a = add_sat64(dd_acc[row][k], c1 * longint'(dcoef_mem[row][i2]));
							a = add_sat64(a, longint'(dcoef_mem[row][i1]) * c2);
							dd_acc[row][k] = a;
						end
					end
					k++;
				end
		for (int j = 0; j < k; j++) begin
			rounded[j] = round_q24(desc_acc[j]).data;
			v = rounded[j];
			sq = v * v;
			sumsq = (sumsq > ~64'd0 - sq) ? ~64'd0 : sumsq + sq;
		end
		norm_val = root64(sumsq);
		for (int row = 0; row < rows; row++) begin
			s = 0;
			for (int j = 0; j < k; j++) begin
				v = int'(round_q24(dd_acc[row][j]).data);
				s = add_sat64(s, v * longint'(rounded[j]));
			end
			dot_acc[row] = s;
		end
	endfunction

	function automatic void predict_command(logic [63:0] w);
		cmd_t        cmd;
		int unsigned ci, di, row, nt;
		int          lv;
		read_result_t r;
		cmd = cmd_t'(w[2:0]);
		ci = w[9:3];
		di = w[17:10];
		row = w[24:18];
		lv = w[56:25];
		nt = w[62:57];
		r.data = '0;
		r.sat = 1'b0;
		unique case (cmd)
			CMD_LOAD_COEF: coef_mem[ci] = lv;
			CMD_LOAD_DERIV: if (row < NROW) dcoef_mem[row][ci] = lv;
			CMD_COMPUTE: begin
				run_spectrum(nt);
				n_computes++;
			end
			CMD_READ_DESC: begin
				if (di < NDESC) r = round_q24(desc_acc[di]);
				read_results_q = {read_results_q, r};
			end
			CMD_READ_DERIV: begin
				if (di < NDESC && row < NROW) r = round_q24(dd_acc[row][di]);
				read_results_q = {read_results_q, r};
			end
			CMD_READ_NORM: begin
				if (norm_val > 32'h7fff_ffff) begin
					r.data = 32'h7fff_ffff;
					r.sat = 1'b1;
				end else begin
					r.data = norm_val;
				end
				read_results_q = {read_results_q, r};
			end
			CMD_READ_DOT: begin
				if (row < NROW) r = round_q24(dot_acc[row]);
				read_results_q = {read_results_q, r};
			end
			default: ;
		endcase
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) predict_command(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
					s_tdata <= cmd_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		read_result_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (read_results_q.size() == 0) begin
					$error("unexpected read result %h", m_tdata);
					errors++;
				end else begin
					e = read_results_q.pop_front();
					if (m_tdata !== e.data) begin
						$error("read_data expected %h actual %h", e.data, m_tdata);
						errors++;
					end
					if (m_tuser[0] !== e.sat) begin
						$error("saturated expected %b actual %b", e.sat, m_tuser[0]);
						errors++;
					end
				end
			end
			m_tready <= quiet || ($urandom_range(0, 99) >= 14);
		end
	end

	function automatic int rand_value();
		unique case ($urandom_range(0, 3))
			0: return int'($urandom());
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
		endcase
	endfunction

	function automatic void push_cmd(cmd_t cmd, int unsigned ci, int unsigned di,
		int unsigned row, int lv, int unsigned nt);
		logic [63:0] w;
		w = {1'b0, nt[5:0], lv[31:0], row[6:0], di[7:0], ci[6:0], 3'(cmd)};
		cmd_q = {cmd_q, w};
		if (cmd == CMD_LOAD_COEF) coef_w[ci[6:0]] = 1'b1;
		if (cmd == CMD_LOAD_DERIV && row < NROW) dcoef_w[row][ci[6:0]] = 1'b1;
	endfunction

	// compute with every needed entry written beforehand
	function automatic void push_compute(int unsigned nt);
		int unsigned r, h, rows;
		r = (gen_radial > 8) ? 8 : gen_radial;
		h = (gen_degree + 1) * (gen_degree + 1);
		rows = 3 * ((nt > 32) ? 32 : nt);
		for (int i = 0; i < r * h; i++) begin
			if (!coef_w[i]) push_cmd(CMD_LOAD_COEF, i, $urandom(), $urandom(), rand_value(),
				$urandom());
			for (int row = 0; row < rows; row++)
				if (!dcoef_w[row][i]) push_cmd(CMD_LOAD_DERIV, i, $urandom(), row,
					rand_value(), $urandom());
		end
		push_cmd(CMD_COMPUTE, $urandom(), $urandom(), $urandom(), $urandom(), nt);
	endfunction

	task automatic wait_idle();
		while (cmd_q.size() > 0 || s_tvalid || read_results_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_RADIAL_COUNT) begin
			pr_radial = val;
			gen_radial = val;
		end else begin
			pr_degree = val[1:0];
			gen_degree = val[1:0];
		end
	endtask

	task automatic random_phase(int count);
		int p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			if (p < 28)
				push_cmd(CMD_LOAD_COEF, $urandom(), $urandom(), $urandom(), rand_value(),
					$urandom());
			else if (p < 52)
				push_cmd(CMD_LOAD_DERIV, $urandom(), $urandom(), $urandom_range(0, 100),
					rand_value(), $urandom());
			else if (p < 53)
				push_compute($urandom_range(0, 1));
			else if (p < 55)
				push_cmd(cmd_t'(3'd7), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
			else
				push_cmd(cmd_t'($urandom_range(3, 6)), $urandom(), $urandom_range(0, 150),
					$urandom_range(0, 100), $urandom(), $urandom());
		end
		push_cmd(CMD_READ_NORM, 0, 0, 0, 0, 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: reads before any compute, extremes, out of range, unknown command
		push_cmd(CMD_READ_DESC, 0, 0, 0, 0, 0);
		push_cmd(CMD_READ_NORM, 0, 0, 0, 0, 0);
		push_cmd(CMD_READ_DOT, 0, 0, 95, 0, 0);
		push_cmd(CMD_LOAD_COEF, 0, 0, 0, 32'h7fff_ffff, 0);
		push_cmd(CMD_LOAD_COEF, 127, 0, 0, 32'h8000_0000, 0);
		push_cmd(CMD_LOAD_DERIV, 0, 0, 0, 32'h7fff_ffff, 0);
		push_cmd(CMD_LOAD_DERIV, 5, 0, 127, 32'h1234_5678, 63);
		push_cmd(cmd_t'(3'd7), 127, 255, 127, 32'hffff_ffff, 63);
		push_compute(1);
		push_cmd(CMD_READ_DESC, 0, 0, 0, 0, 0);
		push_cmd(CMD_READ_DESC, 0, 143, 0, 0, 0);
		push_cmd(CMD_READ_DESC, 0, 255, 0, 0, 0);
		push_cmd(CMD_READ_DERIV, 0, 1, 2, 0, 0);
		push_cmd(CMD_READ_DERIV, 0, 1, 3, 0, 0);
		push_cmd(CMD_READ_DERIV, 0, 0, 127, 0, 0);
		push_cmd(CMD_READ_NORM, 0, 0, 0, 0, 0);
		push_cmd(CMD_READ_DOT, 0, 0, 0, 0, 0);
		push_cmd(CMD_READ_DOT, 0, 0, 127, 0, 0);
		wait_idle();
		// one radial channel, degree zero, neighbor count above the maximum
		write_reg(REG_RADIAL_COUNT, 4'd1);
		write_reg(REG_MAX_DEGREE, 2'd0);
		push_compute(63);
		push_cmd(CMD_READ_DOT, 0, 0, 95, 0, 0);
		push_cmd(CMD_READ_DERIV, 0, 0, 95, 0, 0);
		random_phase(170);
		wait_idle();
		write_reg(REG_RADIAL_COUNT, 4'd0);
		write_reg(REG_MAX_DEGREE, 2'd2);
		push_compute(2);
		random_phase(170);
		wait_idle();
		quiet = 1'b1;
		write_reg(REG_RADIAL_COUNT, 4'd15);
		write_reg(REG_MAX_DEGREE, 2'd3);
		random_phase(170);
		wait_idle();
		quiet = 1'b0;
		write_reg(REG_RADIAL_COUNT, 4'd3);
		write_reg(REG_MAX_DEGREE, 2'd1);
		random_phase(170);
		wait_idle();
		write_reg(REG_RADIAL_COUNT, 4'd8);
		write_reg(REG_MAX_DEGREE, 2'd0);
		random_phase(170);
		wait_idle();
		write_reg(REG_RADIAL_COUNT, 4'($urandom_range(1, 8)));
		write_reg(REG_MAX_DEGREE, 2'($urandom_range(0, 3)));
		random_phase(170);
		wait_idle();
		$display("covered %0d computes and %0d read results over seven register settings",
			n_computes, n_results);
		if (errors == 0) begin
			$display("tb_power_spectrum_descriptor_atoms passed");
		end else begin
			$display("tb_power_spectrum_descriptor_atoms failed");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("tb_power_spectrum_descriptor_atoms failed");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/psd_pkg.sv
src/psd_ram.sv
src/psd_isqrt.sv
src/psd_engine.sv
src/power_spectrum_descriptor_atoms.sv
tb/sv/tb_power_spectrum_descriptor_atoms.sv
